// File: rtl/sid_pkg.sv
// ============================================================================
// sid_pkg
// Shared types and constants for the sorted id set.
// ============================================================================
package sid_pkg;

    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 7;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NULL_ID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    was_present;
    } t_result;

endpackage

// File: rtl/sorted_id_set.sv
// ============================================================================
// sorted_id_set
// Set of nonzero ids kept in ascending order in one on-chip store.
// ============================================================================
// Command channel: an item (i_opcode, i_tag_value) transfers on a rising edge
// with start high and busy low. busy stays high while the item is worked on.
// Result channel: o_done is high for exactly one cycle with o_status,
// o_was_present and o_held_count; the receiver cannot stall it.
// Every item gives one result, in order.
// Opcode 3 and an add of id 0 finish without a search. Every other item
// first runs a binary search of S steps over the n entries held, with S
// at most ceil(log2(n+1)); a lookup, or an item that changes nothing, ends
// there. Add then moves the entries from sorted position p to n - 1 up by
// one and writes the new id at p; remove moves the entries after p down.
// The shift of add and remove moves one entry per cycle through the single
// read and single write port of the store. A new item may be accepted in
// the cycle after the engine finishes, while the previous result is still
// on its way out.
// Reset (synchronous, active low) empties the set at once; the store itself
// is not cleared and needs no sweep.
// ============================================================================
module sorted_id_set #(
    parameter int CAPACITY = 64,
    parameter int ID_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [sid_pkg::TAG_W-1:0]     i_tag_value,
    output logic                          o_done,
    output logic [sid_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_was_present,
    output logic [sid_pkg::HELD_W-1:0]    o_held_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ID_WIDTH-1:0]       key;
    logic [CW-1:0]             w_count;
    logic [sid_pkg::HELD_W-1:0] held;
    logic                      w_res_valid;
    sid_pkg::t_result          w_res;
    logic                      mem_we, mem_re;
    logic [AW-1:0]             mem_waddr, mem_raddr;
    logic [ID_WIDTH-1:0]       mem_wdata, mem_rdata;

    logic                       r_done;
    logic [sid_pkg::STATUS_W-1:0] r_status;
    logic                       r_present;
    logic [sid_pkg::HELD_W-1:0] r_held;

    generate
        if (ID_WIDTH > sid_pkg::TAG_W) begin : g_key_ext
            assign key = {{(ID_WIDTH - sid_pkg::TAG_W){1'b0}}, i_tag_value};
        end else if (ID_WIDTH == sid_pkg::TAG_W) begin : g_key_eq
            assign key = i_tag_value;
        end else begin : g_key_cut
            assign key = i_tag_value[ID_WIDTH-1:0];
        end
        if (CW >= sid_pkg::HELD_W) begin : g_held_cut
            assign held = w_count[sid_pkg::HELD_W-1:0];
        end else begin : g_held_ext
            assign held = {{(sid_pkg::HELD_W - CW){1'b0}}, w_count};
        end
    endgenerate

    sid_engine #(
        .CAPACITY (CAPACITY),
        .ID_WIDTH (ID_WIDTH),
        .AW       (AW),
        .CW       (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_opcode    (i_opcode),
        .i_key       (key),
        .o_busy      (busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_count     (w_count),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    sid_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ID_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_res_valid;
        end
        if (w_res_valid) begin
            r_status  <= w_res.status;
            r_present <= w_res.was_present;
            r_held    <= held;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_was_present = r_present;
    assign o_held_count  = r_held;

    // an accepted command either keeps the engine busy or finishes at once
    a_start_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || w_res_valid))
        else $error("accepted command neither started nor finished");

    // engine only goes idle when it hands over a result
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> w_res_valid)
        else $error("engine went idle without a result");

    // an error status never reports the id as held
    a_error_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != sid_pkg::ST_OK)) |-> !o_was_present)
        else $error("error status with id reported present");

endmodule

// File: rtl/sid_ram.sv
// ============================================================================
// sid_ram
// Id store: one write port, one read port, registered read data.
// ============================================================================
module sid_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sid_engine.sv
// ============================================================================
// sid_engine
// Binary search over the store, then an entry-per-cycle shift for add and
// remove. Holds the entry count.
// ============================================================================
module sid_engine #(
    parameter int CAPACITY = 64,
    parameter int ID_WIDTH = 16,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_opcode,
    input  logic [ID_WIDTH-1:0] i_key,
    output logic                o_busy,
    output logic                o_res_valid,
    output sid_pkg::t_result    o_res,
    output logic [CW-1:0]       o_count,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output logic [ID_WIDTH-1:0] o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    input  logic [ID_WIDTH-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_SHIFT
    } t_state;

    t_state           r_state, n_state;
    sid_pkg::t_opcode r_op, n_op;
    logic [ID_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic             r_found, n_found;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_addr, n_rd_addr;
    logic [CW-1:0]    r_left, n_left;
    logic             r_wr_pend, n_wr_pend;
    logic [CW-1:0]    r_wr_addr, n_wr_addr;
    logic             r_done, n_done;
    sid_pkg::t_result r_res, n_res;
    logic [CW-1:0]    mid;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_count     = r_count;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_done      = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_addr[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_addr[AW-1:0];
        mid         = r_lo + ((r_hi - r_lo) >> 1);

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = sid_pkg::t_opcode'(i_opcode);
                    n_key   = i_key;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_res   = '{status: sid_pkg::ST_OK, was_present: 1'b0};
                    case (sid_pkg::t_opcode'(i_opcode))
                        sid_pkg::OP_ADD: begin
                            if (i_key == '0) begin
                                n_res.status = sid_pkg::ST_NULL_ID;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        sid_pkg::OP_REMOVE, sid_pkg::OP_LOOKUP: begin
                            n_state = S_SEARCH;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = mid[AW-1:0];
                    n_mid       = mid;
                    n_state     = S_CMP;
                end else begin
                    case (r_op)
                        sid_pkg::OP_ADD: begin
                            if (r_found) begin
                                n_res.was_present = 1'b1;
                                n_done            = 1'b1;
                                n_state           = S_IDLE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_res.status = sid_pkg::ST_FULL;
                                n_done       = 1'b1;
                                n_state      = S_IDLE;
                            end else begin
                                n_rd_addr = r_count - CW'(1);
                                n_left    = r_count - r_lo;
                                n_wr_pend = 1'b0;
                                n_state   = S_SHIFT;
                            end
                        end
                        sid_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                n_res.was_present = 1'b1;
                                n_rd_addr         = r_lo + CW'(1);
                                n_left            = r_count - r_lo - CW'(1);
                                n_wr_pend         = 1'b0;
                                n_state           = S_SHIFT;
                            end else begin
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        default: begin
                            n_res.was_present = r_found;
                            n_done            = 1'b1;
                            n_state           = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (i_mem_rdata < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                if (i_mem_rdata == r_key) begin
                    n_found = 1'b1;
                end
                n_state = S_SEARCH;
            end
            S_SHIFT: begin
                if (r_wr_pend) begin
                    o_mem_we = 1'b1;
                end
                if (r_left != '0) begin
                    o_mem_re  = 1'b1;
                    n_wr_pend = 1'b1;
                    n_left    = r_left - CW'(1);
                    if (r_op == sid_pkg::OP_ADD) begin
                        n_wr_addr = r_rd_addr + CW'(1);
                        n_rd_addr = r_rd_addr - CW'(1);
                    end else begin
                        n_wr_addr = r_rd_addr - CW'(1);
                        n_rd_addr = r_rd_addr + CW'(1);
                    end
                end else if (!r_wr_pend) begin
                    if (r_op == sid_pkg::OP_ADD) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_lo[AW-1:0];
                        o_mem_wdata = r_key;
                        n_count     = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_wr_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_done    <= n_done;
            r_wr_pend <= n_wr_pend;
        end
        r_op      <= n_op;
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_found   <= n_found;
        r_rd_addr <= n_rd_addr;
        r_left    <= n_left;
        r_wr_addr <= n_wr_addr;
        r_res     <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_done;
    assign o_res       = r_res;
    assign o_count     = r_count;

endmodule
